>>> rtl/core/u8u16_pkg.sv
package u8u16_pkg;

  localparam int unsigned UnitW   = 16;
  localparam int unsigned PointW  = 21;
  localparam int unsigned MaxRes  = 4;
  localparam int unsigned CntW    = 3;

  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrBadLead  = 2'd1;
  localparam logic [1:0] ErrBadCont  = 2'd2;
  localparam logic [1:0] ErrHighLone = 2'd3;

  localparam logic [PointW-1:0] PointMax    = 21'h10FFFF;
  localparam logic [PointW-1:0] BmpLowMax   = 21'h00D7FF;
  localparam logic [PointW-1:0] BmpHighMin  = 21'h00E000;
  localparam logic [PointW-1:0] BmpMax      = 21'h00FFFF;
  localparam logic [PointW-1:0] SuppBase    = 21'h010000;
  localparam logic [UnitW-1:0]  SurrMask    = 16'hFC00;
  localparam logic [UnitW-1:0]  SurrHigh    = 16'hD800;
  localparam logic [UnitW-1:0]  SurrLow     = 16'hDC00;

  typedef struct packed {
    logic [1:0]        bytes_pending;
    logic [PointW-1:0] point_accum;
    logic              high_held;
    logic              halted;
  } state_t;

  typedef struct packed {
    logic [CntW-1:0]              cnt;
    logic [MaxRes-1:0][UnitW-1:0] units;
    logic [1:0]                   err;
  } res_t;

endpackage

>>> rtl/core/u8u16_step.sv
module u8u16_step (
  input  logic                    direction_i,
  input  logic [15:0]             unit_i,
  input  logic                    first_i,
  input  u8u16_pkg::state_t       state_i,
  output u8u16_pkg::state_t       state_o,
  output u8u16_pkg::res_t         res_o
);
  import u8u16_pkg::*;

  function automatic res_t enc_utf16(input logic [PointW-1:0] p);
    res_t              r;
    logic [PointW-1:0] v;
    r = '0;
    v = p - SuppBase;
    if (p <= BmpLowMax || (p >= BmpHighMin && p <= BmpMax)) begin
      r.cnt      = CntW'(1);
      r.units[0] = p[UnitW-1:0];
    end else if (p >= SuppBase && p <= PointMax) begin
      r.cnt      = CntW'(2);
      r.units[0] = SurrHigh | {6'd0, v[19:10]};
      r.units[1] = SurrLow | {6'd0, v[9:0]};
    end
    return r;
  endfunction

  function automatic res_t enc_utf8(input logic [PointW-1:0] p);
    res_t r;
    r = '0;
    if (p <= 21'h7F) begin
      r.cnt      = CntW'(1);
      r.units[0] = {9'd0, p[6:0]};
    end else if (p <= 21'h7FF) begin
      r.cnt      = CntW'(2);
      r.units[0] = {8'd0, 3'b110, p[10:6]};
      r.units[1] = {8'd0, 2'b10, p[5:0]};
    end else if (p <= 21'hFFFF) begin
      r.cnt      = CntW'(3);
      r.units[0] = {8'd0, 4'b1110, p[15:12]};
      r.units[1] = {8'd0, 2'b10, p[11:6]};
      r.units[2] = {8'd0, 2'b10, p[5:0]};
    end else begin
      r.cnt      = CntW'(4);
      r.units[0] = {8'd0, 5'b11110, p[20:18]};
      r.units[1] = {8'd0, 2'b10, p[17:12]};
      r.units[2] = {8'd0, 2'b10, p[11:6]};
      r.units[3] = {8'd0, 2'b10, p[5:0]};
    end
    return r;
  endfunction

  state_t            s;
  res_t              r;
  logic [7:0]        b;
  logic [PointW-1:0] acc;
  logic              is_high;
  logic              is_low;
  logic              fail;
  logic [1:0]        fail_kind;

  always_comb begin
    s         = state_i;
    r         = '0;
    b         = unit_i[7:0];
    acc       = '0;
    fail      = 1'b0;
    fail_kind = ErrNone;
    is_high   = (unit_i & SurrMask) == SurrHigh;
    is_low    = (unit_i & SurrMask) == SurrLow;
    if (first_i) begin
      s = '0;
    end
    if (!s.halted) begin
      if (!direction_i) begin
        if (s.bytes_pending == 2'd0) begin
          if (!b[7]) begin
            r = enc_utf16({13'd0, b});
          end else if (b[7:5] == 3'b110) begin
            s.point_accum   = {16'd0, b[4:0]};
            s.bytes_pending = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            s.point_accum   = {17'd0, b[3:0]};
            s.bytes_pending = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            s.point_accum   = {18'd0, b[2:0]};
            s.bytes_pending = 2'd3;
          end else begin
            fail      = 1'b1;
            fail_kind = ErrBadLead;
          end
        end else if (b[7:6] != 2'b10) begin
          fail      = 1'b1;
          fail_kind = ErrBadCont;
        end else begin
          acc             = {s.point_accum[PointW-7:0], b[5:0]};
          s.bytes_pending = s.bytes_pending - 2'd1;
          if (s.bytes_pending == 2'd0) begin
            s.point_accum = '0;
            r             = enc_utf16(acc);
          end else begin
            s.point_accum = acc;
          end
        end
      end else begin
        if (s.high_held) begin
          if (!is_low) begin
            fail      = 1'b1;
            fail_kind = ErrHighLone;
          end else begin
            acc           = {1'b0, s.point_accum[9:0], unit_i[9:0]} + SuppBase;
            s.high_held   = 1'b0;
            s.point_accum = '0;
            r             = enc_utf8(acc);
          end
        end else if (is_high) begin
          s.high_held   = 1'b1;
          s.point_accum = {5'd0, unit_i};
        end else begin
          r = enc_utf8({5'd0, unit_i});
        end
      end
      if (fail) begin
        s        = '0;
        s.halted = 1'b1;
        r        = '0;
        r.cnt    = CntW'(1);
        r.err    = fail_kind;
      end
    end
    state_o = s;
    res_o   = r;
  end

endmodule

>>> rtl/core/utf8_utf16_transcoder_unit.sv
// Path: an item's results reach the master side through the input register,
//   the step logic and the result buffer.
// Throughput: one input item per cycle while the receiver is ready and each
//   item gives at most one result; n results hold the buffer until drained.
// Reset: rst_ni asynchronous, active low; clears direction, decoder state
//   and all valid flags.
module utf8_utf16_transcoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: direction register
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  input  logic        s_axis_tuser,   // [0] first
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] out_unit
  output logic        m_axis_tlast,   // last_of_run
  output logic [1:0]  m_axis_tuser    // [1:0] error_kind
);
  import u8u16_pkg::*;

  // configuration and decoder state
  logic   dir_q;
  state_t st_q;
  state_t st_d;
  res_t   res;

  // input register
  logic             in_valid_q;
  logic [UnitW-1:0] in_unit_q;
  logic             in_first_q;

  // result buffer: up to four units drained one per transaction
  logic [CntW-1:0]              buf_cnt_q;
  logic [1:0]                   buf_idx_q;
  logic [MaxRes-1:0][UnitW-1:0] buf_units_q;
  logic [1:0]                   buf_err_q;

  logic buf_pop;
  logic buf_done;
  logic buf_free;
  logic in_adv;
  logic in_take;

  u8u16_step u_step (
    .direction_i (dir_q),
    .unit_i      (in_unit_q),
    .first_i     (in_first_q),
    .state_i     (st_q),
    .state_o     (st_d),
    .res_o       (res)
  );

  assign m_axis_tvalid = buf_cnt_q != '0;
  assign m_axis_tdata  = buf_units_q[buf_idx_q];
  assign m_axis_tlast  = ({1'b0, buf_idx_q} + CntW'(1)) == buf_cnt_q;
  assign m_axis_tuser  = buf_err_q;

  assign buf_pop  = m_axis_tvalid && m_axis_tready;
  assign buf_done = buf_pop && m_axis_tlast;
  assign buf_free = (buf_cnt_q == '0) || buf_done;

  // advance an item that makes no results regardless of the buffer
  assign in_adv        = in_valid_q && ((res.cnt == '0) || buf_free);
  assign s_axis_tready = !in_valid_q || in_adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (in_adv) begin
      in_valid_q <= 1'b0;
    end
  end

  // hold the payload; no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_unit_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
    end
  end

  // direction write drops any partial sequence but keeps the halt flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      st_q  <= '0;
    end else if (cfg_we_i) begin
      dir_q              <= cfg_wdata_i;
      st_q.bytes_pending <= '0;
      st_q.point_accum   <= '0;
      st_q.high_held     <= 1'b0;
    end else if (in_adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_cnt_q <= '0;
      buf_idx_q <= '0;
    end else if (in_adv && (res.cnt != '0)) begin
      buf_cnt_q <= res.cnt;
      buf_idx_q <= '0;
    end else if (buf_done) begin
      buf_cnt_q <= '0;
    end else if (buf_pop) begin
      buf_idx_q <= buf_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && (res.cnt != '0)) begin
      buf_units_q <= res.units;
      buf_err_q   <= res.err;
    end
  end

endmodule

>>> rtl/core/u8u16_checker.sv
module u8u16_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);
  import u8u16_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // an error result is the only one of its item and carries a zero unit
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ErrNone) |->
      m_axis_tlast && (m_axis_tdata == '0))
    else $error("malformed error result");

  // with nothing waiting on the output the input side must be open
  a_skid_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result buffer");

  // an error result never leaves while another result of the run follows
  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      !m_axis_tvalid || (m_axis_tuser == ErrNone))
    else $error("error result inside a run");

endmodule

bind utf8_utf16_transcoder_unit u8u16_checker u_u8u16_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import u8u16_pkg::*;

  // Generous bound: every item at four results, each result behind the longest
  // receiver stall, plus sender gaps, the hold-off and the settle pauses.
  localparam int CycleLimit    = 200000;
  // Stretch the receiver stays stalled during the back-pressure phase.
  localparam int HoldOffCycles = 150;
  // Cycles to let an item that gives no result clear the input register and
  // the result buffer before the direction register is touched.
  localparam int SettleCycles  = 4;

  // One expected transaction on the master side.
  typedef struct {
    logic [15:0] unit;
    logic        last;
    logic [1:0]  err;
  } unit_result_t;

  // Transcoder predictor plus the queue of results still owed by the block.
  class transcode_scoreboard;
    bit             direction;
    logic [1:0]     pend;
    logic [20:0]    accum;
    bit             high_held;
    bit             halted;
    unit_result_t   run_q[$];
    unit_result_t   expected_q[$];
    int             errors;

    function void set_direction(bit d);
      direction = d;
      pend      = 2'd0;
      accum     = '0;
      high_held = 1'b0;
    endfunction

    function void add(logic [15:0] u, logic [1:0] err);
      unit_result_t e;
      e.unit = u;
      e.last = 1'b0;
      e.err  = err;
      run_q.push_back(e);
    endfunction

    function void abort(logic [1:0] err);
      halted    = 1'b1;
      pend      = 2'd0;
      accum     = '0;
      high_held = 1'b0;
      run_q.delete();
      add(16'h0000, err);
    endfunction

    function void emit_utf16(logic [20:0] p);
      logic [20:0] v;
      if (p <= BmpLowMax || (p >= BmpHighMin && p <= BmpMax)) begin
        add(p[15:0], ErrNone);
      end else if (p >= SuppBase && p <= PointMax) begin
        v = p - SuppBase;
        add(SurrHigh | {6'd0, v[19:10]}, ErrNone);
        add(SurrLow | {6'd0, v[9:0]}, ErrNone);
      end
    endfunction

    function void emit_utf8(logic [20:0] p);
      if (p <= 21'h7F) begin
        add({9'd0, p[6:0]}, ErrNone);
      end else if (p <= 21'h7FF) begin
        add({8'd0, 3'b110, p[10:6]}, ErrNone);
        add({8'd0, 2'b10, p[5:0]}, ErrNone);
      end else if (p <= 21'hFFFF) begin
        add({8'd0, 4'b1110, p[15:12]}, ErrNone);
        add({8'd0, 2'b10, p[11:6]}, ErrNone);
        add({8'd0, 2'b10, p[5:0]}, ErrNone);
      end else begin
        add({8'd0, 5'b11110, p[20:18]}, ErrNone);
        add({8'd0, 2'b10, p[17:12]}, ErrNone);
        add({8'd0, 2'b10, p[11:6]}, ErrNone);
        add({8'd0, 2'b10, p[5:0]}, ErrNone);
      end
    endfunction

    // Advance the predictor by one accepted input transaction; returns 0 when
    // the block is halted and ignores it.
    function bit note_input(logic [15:0] code, logic first);
      logic [7:0]  b;
      logic [20:0] p;
      logic        is_high;
      logic        is_low;
      run_q.delete();
      if (first) begin
        pend      = 2'd0;
        accum     = '0;
        high_held = 1'b0;
        halted    = 1'b0;
      end
      if (halted) return 1'b0;
      if (!direction) begin
        b = code[7:0];
        if (pend == 2'd0) begin
          if (b <= 8'h7F) begin
            emit_utf16({13'd0, b});
          end else if (b >= 8'hC0 && b <= 8'hDF) begin
            accum = {16'd0, b[4:0]};
            pend  = 2'd1;
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            accum = {17'd0, b[3:0]};
            pend  = 2'd2;
          end else if (b >= 8'hF0 && b <= 8'hF7) begin
            accum = {18'd0, b[2:0]};
            pend  = 2'd3;
          end else begin
            abort(ErrBadLead);
          end
        end else if (b[7:6] != 2'b10) begin
          abort(ErrBadCont);
        end else begin
          accum = {accum[14:0], b[5:0]};
          pend  = pend - 2'd1;
          if (pend == 2'd0) begin
            p     = accum;
            accum = '0;
            emit_utf16(p);
          end
        end
      end else begin
        is_high = (code & SurrMask) == SurrHigh;
        is_low  = (code & SurrMask) == SurrLow;
        if (high_held) begin
          if (!is_low) begin
            abort(ErrHighLone);
          end else begin
            p         = {1'b0, accum[9:0], code[9:0]} + SuppBase;
            high_held = 1'b0;
            accum     = '0;
            emit_utf8(p);
          end
        end else if (is_high) begin
          high_held = 1'b1;
          accum     = {5'd0, code};
        end else begin
          emit_utf8({5'd0, code});
        end
      end
      if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
      foreach (run_q[i]) expected_q.push_back(run_q[i]);
      return 1'b1;
    endfunction

    task report(string what);
      errors++;
      $display("ERROR @%0t: %s", $time, what);
    endtask

    task check_result(logic [15:0] u, logic l, logic [1:0] err);
      unit_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result unit %h last %b err %0d", u, l, err));
      end else begin
        e = expected_q.pop_front();
        if (u !== e.unit) report($sformatf("out_unit %h, expected %h", u, e.unit));
        if (l !== e.last) report($sformatf("last_of_run %b, expected %b", l, e.last));
        if (err !== e.err) report($sformatf("error_kind %0d, expected %0d", err, e.err));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] code_unit
  logic        s_axis_tuser;   // [0] first
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] out_unit
  logic        m_axis_tlast;   // last_of_run
  logic [1:0]  m_axis_tuser;   // [1:0] error_kind

  transcode_scoreboard sb;
  int          live_items;
  int          cycle_cnt;
  bit          tx_quiet;
  bit          rx_quiet;
  bit          hold_off_req;
  logic [15:0] char_units[$];

  utf8_utf16_transcoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle length: mostly none, often a few cycles, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Queue one UTF-8 byte; the upper byte of code_unit is don't-care, so
  // randomize it.
  function automatic void add_byte(logic [7:0] b);
    logic [7:0] hi;
    hi = 8'($urandom_range(0, 255));
    char_units.push_back({hi, b});
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [5:0] c;
    c = 6'($urandom_range(0, 63));
    return {2'b10, c};
  endfunction

  // Build one UTF-8 character, mostly well formed, including overlong forms,
  // encoded surrogates, points past the top of Unicode and a broken sequence.
  function automatic void build_utf8_char();
    logic [20:0] p;
    logic [7:0]  b;
    case ($urandom_range(0, 9))
      0, 1: begin
        b = 8'($urandom_range(0, 8'h7F));
        add_byte(b);
      end
      2, 3: begin
        b = 8'($urandom_range(8'hC0, 8'hDF));
        add_byte(b);
        add_byte(cont_byte());
      end
      4, 5: begin
        b = 8'($urandom_range(8'hE0, 8'hEF));
        add_byte(b);
        add_byte(cont_byte());
        add_byte(cont_byte());
      end
      6, 7: begin
        p = 21'($urandom_range(21'h10000, 21'h10FFFF));
        add_byte({5'b11110, p[20:18]});
        add_byte({2'b10, p[17:12]});
        add_byte({2'b10, p[11:6]});
        add_byte({2'b10, p[5:0]});
      end
      8: begin
        b = 8'($urandom_range(8'hF0, 8'hF7));
        add_byte(b);
        add_byte(cont_byte());
        add_byte(cont_byte());
        add_byte(cont_byte());
      end
      default: begin
        // cut a sequence short with an arbitrary byte
        b = 8'($urandom_range(8'hE0, 8'hEF));
        add_byte(b);
        b = 8'($urandom_range(0, 255));
        add_byte(b);
      end
    endcase
  endfunction

  // Build one UTF-16 character: BMP units, pairs, a lone low surrogate, an
  // unpaired high surrogate and a high surrogate left open at string end.
  function automatic void build_utf16_char();
    logic [15:0] u;
    logic [9:0]  s;
    case ($urandom_range(0, 9))
      0: char_units.push_back(16'($urandom_range(0, 16'h7F)));
      1: char_units.push_back(16'($urandom_range(16'h80, 16'h7FF)));
      2, 3: begin
        u = 16'($urandom_range(0, 16'hFFFF));
        if ((u & SurrMask) == SurrHigh || (u & SurrMask) == SurrLow) u ^= 16'h2000;
        char_units.push_back(u);
      end
      4, 5, 6: begin
        s = 10'($urandom_range(0, 10'h3FF));
        char_units.push_back(SurrHigh | {6'd0, s});
        s = 10'($urandom_range(0, 10'h3FF));
        char_units.push_back(SurrLow | {6'd0, s});
      end
      7: begin
        s = 10'($urandom_range(0, 10'h3FF));
        char_units.push_back(SurrLow | {6'd0, s});
      end
      8: begin
        s = 10'($urandom_range(0, 10'h3FF));
        char_units.push_back(SurrHigh | {6'd0, s});
        u = 16'($urandom_range(0, 16'hFFFF));
        if ((u & SurrMask) == SurrLow) u ^= 16'h0800;
        char_units.push_back(u);
      end
      default: begin
        s = 10'($urandom_range(0, 10'h3FF));
        char_units.push_back(SurrHigh | {6'd0, s});
      end
    endcase
  endfunction

  // Offer one transaction on the slave side and hold it until accepted.
  // Keep tvalid high across back-to-back transactions.
  task send_item(input logic [15:0] code, input logic first);
    int gap;
    gap = tx_quiet ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    if (sb.note_input(code, first)) live_items++;
  endtask

  // Drop tvalid, wait for every owed result, then let the pipeline empty.
  task settle_block();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task write_direction(input bit d);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_direction(d);
  endtask

  // Stream random strings in the current direction until the block has
  // processed about target transactions. Each string opens with first set;
  // a small share of units is plain noise.
  task send_text(input int target, input bit eager);
    int stop_at;
    int n_chars;
    bit f;
    stop_at = live_items + target;
    while (live_items < stop_at) begin
      tx_quiet = eager || ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      n_chars  = $urandom_range(1, 6);
      f        = 1'b1;
      for (int c = 0; c < n_chars; c++) begin
        char_units.delete();
        if ($urandom_range(0, 99) < 12) char_units.push_back(16'($urandom_range(0, 16'hFFFF)));
        else if (sb.direction) build_utf16_char();
        else build_utf8_char();
        foreach (char_units[k]) begin
          send_item(char_units[k], f | ($urandom_range(0, 40) == 0));
          f = 1'b0;
        end
      end
    end
  endtask

  // Check every master-side transaction against the oldest expectation.
  // Sample at the edge so values are those the handshake used.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off on request.
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int i = 0; i < HoldOffCycles; i++) @(posedge clk_i);
      end else begin
        stall = rx_quiet ? 0 : gap_len();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: end the run if it ever hangs.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("utf8_utf16_transcoder_unit test failed");
    $finish;
  end

  initial begin : stimulus
    logic [16:0] script[$];   // {first, code_unit}
    sb            = new();
    live_items    = 0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    hold_off_req  = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // UTF-8 to UTF-16 corner cases
    write_direction(1'b0);
    script = '{
      17'h1_0000,                                      // NUL, new string
      17'h0_FF7F,                                      // top ASCII, upper byte ignored
      17'h0_00C2, 17'h0_00A9,                          // two-byte form
      17'h0_00C0, 17'h0_0080,                          // overlong NUL, decoded as is
      17'h0_00EF, 17'h0_00BF, 17'h0_00BF,              // U+FFFF
      17'h0_00ED, 17'h0_00A0, 17'h0_0080,              // encoded surrogate: no result
      17'h0_00F4, 17'h0_008F, 17'h0_00BF, 17'h0_00BF,  // U+10FFFF: surrogate pair
      17'h1_00BF,                                      // stray continuation: bad lead
      17'h0_0041,                                      // halted: ignored
      17'h1_00E2, 17'h0_0041                           // bad continuation
    };
    foreach (script[i]) send_item(script[i][15:0], script[i][16]);

    // Switch direction while halted; the halt must survive the write.
    settle_block();
    write_direction(1'b1);
    script = '{
      17'h0_0041,                                      // still halted: ignored
      17'h1_DBFF, 17'h0_DFFF,                          // top pair: four bytes
      17'h0_DC00,                                      // lone low: three bytes
      17'h0_D800, 17'h0_0041,                          // unpaired high surrogate
      17'h1_D800, 17'h1_0000,                          // held high dropped by first
      17'h0_FFFF                                       // top unit
    };
    foreach (script[i]) send_item(script[i][15:0], script[i][16]);

    // Random UTF-16 text with one mid-phase pause until all results are back.
    send_text(8, 1'b0);
    settle_block();
    send_text(8, 1'b0);

    // Back-pressure: stall the receiver long while the sender keeps offering.
    hold_off_req = 1'b1;
    send_text(15, 1'b1);
    settle_block();

    write_direction(1'b0);
    send_text(20, 1'b0);
    settle_block();

    write_direction(1'b1);
    send_text(6, 1'b0);
    settle_block();

    if (sb.expected_q.size() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.expected_q.size()));
    end
    if (sb.errors == 0) begin
      $display("utf8_utf16_transcoder_unit test passed");
    end else begin
      $display("utf8_utf16_transcoder_unit test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_step.sv
rtl/core/utf8_utf16_transcoder_unit.sv
rtl/core/u8u16_checker.sv
tb/tb.sv
